// ===== rtl/pwmv_pkg.sv =====
// ----------------------------------------------------------------------------
// pwmv_pkg
// shared types, constants and helpers of the per-track window majority vote
// ----------------------------------------------------------------------------
package pwmv_pkg;

    localparam int NUM_TRACKS = 256;
    localparam int TRACK_W    = $clog2(NUM_TRACKS);
    localparam int MAX_WINDOW = 16;
    localparam int POS_W      = $clog2(MAX_WINDOW);
    localparam int MAX_LEVELS = 8;
    localparam int LVL_W      = $clog2(MAX_LEVELS);
    localparam int CNT_W      = 5;     // window size, fill count, votes
    localparam int NL_W       = 4;     // level count register
    localparam int RING_AW    = TRACK_W + POS_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_LEVELS  = 1'd1;
    localparam logic [CNT_W-1:0]     WINDOW_RESET    = 5'd8;
    localparam logic [NL_W-1:0]      LEVELS_RESET    = 4'd5;

    // request queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic [LVL_W-1:0]   level;
        logic               bad;
    } pwmv_item_t;

    typedef struct packed {
        logic [POS_W-1:0]                   wpos;
        logic [CNT_W-1:0]                   fill;
        logic [MAX_LEVELS-1:0][CNT_W-1:0]   votes;
    } pwmv_rec_t;

    // window size clamped to 1 .. MAX_WINDOW
    function automatic logic [CNT_W-1:0] eff_window(input logic [CNT_W-1:0] ws);
        logic [CNT_W-1:0] r;
        r = ws;
        if (ws == '0)
        begin
            r = CNT_W'(1);
        end
        else if (ws > CNT_W'(MAX_WINDOW))
        begin
            r = CNT_W'(MAX_WINDOW);
        end
        return r;
    endfunction

    // level count clamped to 1 .. MAX_LEVELS
    function automatic logic [NL_W-1:0] eff_levels(input logic [NL_W-1:0] nl);
        logic [NL_W-1:0] r;
        r = nl;
        if (nl == '0)
        begin
            r = NL_W'(1);
        end
        else if (nl > NL_W'(MAX_LEVELS))
        begin
            r = NL_W'(MAX_LEVELS);
        end
        return r;
    endfunction

endpackage

// ===== rtl/per_track_window_majority_vote_top.sv =====
// ----------------------------------------------------------------------------
// per_track_window_majority_vote_top
// per-track sliding-window majority vote over predicted levels
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       to block   in_valid / in_stall  track_id, predicted_level
//  out      from block out_valid / out_stall voted_level, winning_votes,
//                                           history_length, bad_level
//  cfg      to block   cfg_we               cfg_index, cfg_data
//
//  in the back end a request goes through a track record read, a history ring
//  read, a record and ring write and a vote over the level counts
//  the front end and a two-entry queue keep taking requests while the back
//  end works or while a result waits in the output register
//  reset and any register write empty every track through per-track valid
//  bits, so there is no clearing pass
//  a stalled output holds the back end in its vote step
// ----------------------------------------------------------------------------
module per_track_window_majority_vote_top
    import pwmv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              track_id,
    input  logic [2:0]              predicted_level,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              voted_level,
    output logic [4:0]              winning_votes,
    output logic [4:0]              history_length,
    output logic                    bad_level,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    // configuration registers
    logic [CNT_W-1:0]   window_size_reg;
    logic [NL_W-1:0]    num_levels_reg;
    logic               store_clear;

    // effective settings after clamping
    logic [CNT_W-1:0]   win;
    logic [NL_W-1:0]    nl;

    // front to queue to back
    logic               q_full;
    logic               q_push;
    pwmv_item_t         q_push_item;
    logic               q_valid;
    pwmv_item_t         q_item;
    logic               q_pop;

    assign win = eff_window(window_size_reg);
    assign nl  = eff_levels(num_levels_reg);

    // every register write empties the store
    always_comb
    begin
        store_clear = 1'b0;
        case (cfg_index)
            REG_WINDOW_SIZE: store_clear = cfg_we;
            REG_NUM_LEVELS:  store_clear = cfg_we;
            default:         store_clear = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_RESET;
            num_levels_reg  <= LEVELS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_SIZE: window_size_reg <= cfg_data[CNT_W-1:0];
                REG_NUM_LEVELS:  num_levels_reg  <= cfg_data[NL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // classify incoming requests
    pwmv_front u_front (
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .track_id        (track_id),
        .predicted_level (predicted_level),
        .nl              (nl),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_push_item     (q_push_item)
    );

    // decouple the front end from the back end
    pwmv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop)
    );

    // per-track update and vote
    pwmv_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .store_clear    (store_clear),
        .win            (win),
        .nl             (nl),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .voted_level    (voted_level),
        .winning_votes  (winning_votes),
        .history_length (history_length),
        .bad_level      (bad_level)
    );

`ifndef ASSERT_OFF
    // the winner never holds more votes than the history has entries
    a_votes_in_history: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (winning_votes <= history_length))
        else $error("winning votes exceed history length");

    // history never grows past the window
    a_length_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (history_length <= win))
        else $error("history length exceeds window");

    // the voted level is always one of the valid levels
    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, voted_level} < nl))
        else $error("voted level out of range");

    // with no votes the result falls back to level zero
    a_empty_vote: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (winning_votes == '0)) |-> (voted_level == '0))
        else $error("empty vote with nonzero level");
`endif

endmodule

// ===== rtl/pwmv_front.sv =====
// ----------------------------------------------------------------------------
// pwmv_front
// accepts requests, folds the track id and flags out-of-range levels
// ----------------------------------------------------------------------------
module pwmv_front
    import pwmv_pkg::*;
(
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         track_id,
    input  logic [2:0]         predicted_level,
    input  logic [NL_W-1:0]    nl,
    input  logic               q_full,
    output logic               q_push,
    output pwmv_item_t         q_push_item
);

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_push_item.track = track_id[TRACK_W-1:0];
        q_push_item.level = predicted_level;
        // level not below the level count is ignored by the back end
        q_push_item.bad   = ({1'b0, predicted_level} >= nl);
    end

endmodule

// ===== rtl/pwmv_queue.sv =====
// ----------------------------------------------------------------------------
// pwmv_queue
// short request queue between front and back
// ----------------------------------------------------------------------------
module pwmv_queue
    import pwmv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  pwmv_item_t  push_item,
    output logic        full,
    output logic        q_valid,
    output pwmv_item_t  q_item,
    input  logic        pop
);

    pwmv_item_t           entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 do_pop;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/pwmv_back.sv =====
// ----------------------------------------------------------------------------
// pwmv_back
// read-modify-write of a track record and its history ring, then the vote
// ----------------------------------------------------------------------------
module pwmv_back
    import pwmv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               store_clear,
    input  logic [CNT_W-1:0]   win,
    input  logic [NL_W-1:0]    nl,
    input  logic               q_valid,
    input  pwmv_item_t         q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         voted_level,
    output logic [4:0]         winning_votes,
    output logic [4:0]         history_length,
    output logic               bad_level
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RING   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_VOTE   = 4'b1000
    } pwmv_state_t;

    pwmv_state_t                        state_reg;
    pwmv_state_t                        state_next;

    // storage
    pwmv_rec_t                          track_mem [NUM_TRACKS];
    logic [LVL_W-1:0]                   ring_mem  [NUM_TRACKS*MAX_WINDOW];
    logic [NUM_TRACKS-1:0]              valid_reg;

    // per-request working registers
    pwmv_item_t                         item_reg;
    pwmv_rec_t                          rec_rd_reg;
    logic                               valid_rd_reg;
    pwmv_rec_t                          rec_reg;
    pwmv_rec_t                          rec_sel;
    pwmv_rec_t                          rec_n;
    logic [LVL_W-1:0]                   ring_rd_reg;
    logic [RING_AW-1:0]                 ring_rd_addr;
    logic [RING_AW-1:0]                 ring_wr_addr;
    logic [MAX_LEVELS-1:0][CNT_W-1:0]   votes_reg;
    logic [CNT_W-1:0]                   len_reg;
    logic [CNT_W-1:0]                   pos_inc;
    logic                               wr_en;

    // vote and output
    logic [LVL_W-1:0]                   best_lvl;
    logic [CNT_W-1:0]                   best_cnt;
    logic                               out_free;
    logic                               out_valid_reg;
    logic [LVL_W-1:0]                   voted_level_reg;
    logic [CNT_W-1:0]                   winning_votes_reg;
    logic [CNT_W-1:0]                   history_length_reg;
    logic                               bad_level_reg;

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign out_free = !out_valid_reg || !out_stall;
    assign wr_en    = (state_reg == ST_UPDATE) && !item_reg.bad;

    // record of the track, empty when the track has not started
    always_comb
    begin
        rec_sel = valid_rd_reg ? rec_rd_reg : '0;
        if ({1'b0, rec_sel.wpos} >= win)
        begin
            rec_sel.wpos = '0;
        end
        ring_rd_addr = {item_reg.track, rec_sel.wpos};
        ring_wr_addr = {item_reg.track, rec_reg.wpos};
    end

    // record update: retire the oldest level once full, count the new one
    always_comb
    begin
        rec_n = rec_reg;
        if (rec_reg.fill >= win)
        begin
            if (rec_n.votes[ring_rd_reg] != '0)
            begin
                rec_n.votes[ring_rd_reg] = rec_n.votes[ring_rd_reg] - CNT_W'(1);
            end
        end
        else
        begin
            rec_n.fill = rec_reg.fill + CNT_W'(1);
        end
        rec_n.votes[item_reg.level] = rec_n.votes[item_reg.level] + CNT_W'(1);
        pos_inc = {1'b0, rec_reg.wpos} + CNT_W'(1);
        if (pos_inc >= win)
        begin
            pos_inc = '0;
        end
        rec_n.wpos = pos_inc[POS_W-1:0];
    end

    // most votes among the valid levels, lowest level on a tie
    always_comb
    begin
        best_lvl = '0;
        best_cnt = '0;
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            if ((NL_W'(i) < nl) && (votes_reg[i] > best_cnt))
            begin
                best_cnt = votes_reg[i];
                best_lvl = LVL_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_RING;
                end
            end
            ST_RING:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_VOTE;
            end
            ST_VOTE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (store_clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[item_reg.track] <= 1'b1;
            end
            if ((state_reg == ST_VOTE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        rec_rd_reg   <= track_mem[q_item.track];
        valid_rd_reg <= valid_reg[q_item.track];
        ring_rd_reg  <= ring_mem[ring_rd_addr];
        if (wr_en)
        begin
            track_mem[item_reg.track] <= rec_n;
            ring_mem[ring_wr_addr]    <= item_reg.level;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == ST_RING)
        begin
            rec_reg <= rec_sel;
        end
        if (state_reg == ST_UPDATE)
        begin
            votes_reg <= item_reg.bad ? rec_reg.votes : rec_n.votes;
            len_reg   <= item_reg.bad ? rec_reg.fill : rec_n.fill;
        end
        if ((state_reg == ST_VOTE) && out_free)
        begin
            voted_level_reg    <= best_lvl;
            winning_votes_reg  <= best_cnt;
            history_length_reg <= len_reg;
            bad_level_reg      <= item_reg.bad;
        end
    end

    assign out_valid      = out_valid_reg;
    assign voted_level    = voted_level_reg;
    assign winning_votes  = winning_votes_reg;
    assign history_length = history_length_reg;
    assign bad_level      = bad_level_reg;

endmodule

// ===== tb/window_vote_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_vote_checker
// watches the request, result and register channels of the majority vote
// block, keeps its own copy of every track history and compares each result
// against the vote that the history calls for
// ----------------------------------------------------------------------------
module window_vote_checker
    import pwmv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [7:0]              track_id,
    input  logic [2:0]              predicted_level,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [2:0]              voted_level,
    input  logic [4:0]              winning_votes,
    input  logic [4:0]              history_length,
    input  logic                    bad_level,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output int                      fail_count,
    output int                      pending
);

    typedef struct packed {
        logic [2:0] level;
        logic [4:0] votes;
        logic [4:0] length;
        logic       bad;
    } vote_result_t;

    logic [4:0] window_reg;
    logic [3:0] levels_reg;

    // per-track history mirror
    logic       track_live [NUM_TRACKS];
    logic [3:0] ring_pos   [NUM_TRACKS];
    logic [4:0] track_fill [NUM_TRACKS];
    logic [2:0] level_hist [NUM_TRACKS*MAX_WINDOW];
    logic [4:0] vote_count [NUM_TRACKS*MAX_LEVELS];

    vote_result_t expected_votes [$];

    function automatic void forget_tracks();
        for (int i = 0; i < NUM_TRACKS; i++)
        begin
            track_live[i] = 1'b0;
        end
    endfunction

    // push one prediction into the track history and vote over the window
    function automatic vote_result_t predict_vote(input logic [7:0] trk,
                                                  input logic [2:0] lvl);
        vote_result_t r;
        int t;
        int win;
        int nl;
        int pos;
        int vb;
        int rb;
        logic [2:0] oldest;
        r   = '0;
        t   = int'(trk) % NUM_TRACKS;
        win = (window_reg == 0) ? 1 :
              ((window_reg > MAX_WINDOW) ? MAX_WINDOW : int'(window_reg));
        nl  = (levels_reg == 0) ? 1 :
              ((levels_reg > MAX_LEVELS) ? MAX_LEVELS : int'(levels_reg));
        vb  = t * MAX_LEVELS;
        rb  = t * MAX_WINDOW;
        r.bad = (int'(lvl) >= nl);
        if (!r.bad)
        begin
            if (!track_live[t])
            begin
                track_live[t] = 1'b1;
                ring_pos[t]   = '0;
                track_fill[t] = '0;
                for (int i = 0; i < MAX_LEVELS; i++)
                begin
                    vote_count[vb + i] = '0;
                end
            end
            pos = int'(ring_pos[t]);
            if (pos >= win)
            begin
                pos = 0;
            end
            if (int'(track_fill[t]) >= win)
            begin
                // ring full: the oldest level loses its vote
                oldest = level_hist[rb + pos];
                if (vote_count[vb + oldest] > 0)
                begin
                    vote_count[vb + oldest] = vote_count[vb + oldest] - 1'b1;
                end
            end
            else
            begin
                track_fill[t] = track_fill[t] + 1'b1;
            end
            level_hist[rb + pos] = lvl;
            vote_count[vb + lvl] = vote_count[vb + lvl] + 1'b1;
            pos = pos + 1;
            if (pos >= win)
            begin
                pos = 0;
            end
            ring_pos[t] = 4'(pos);
        end
        if (track_live[t])
        begin
            r.length = track_fill[t];
            for (int i = 0; i < nl; i++)
            begin
                // strict compare keeps the lowest level on a tie
                if (vote_count[vb + i] > r.votes)
                begin
                    r.votes = vote_count[vb + i];
                    r.level = 3'(i);
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [4:0] want,
                               input logic [4:0] seen);
        if (want !== seen)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        vote_result_t want;
        if (!rst_n)
        begin
            window_reg = WINDOW_RESET;
            levels_reg = LEVELS_RESET;
            forget_tracks();
            expected_votes.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_WINDOW_SIZE)
                begin
                    window_reg = cfg_data[4:0];
                    forget_tracks();
                end
                else if (cfg_index == REG_NUM_LEVELS)
                begin
                    levels_reg = cfg_data[3:0];
                    forget_tracks();
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_votes.insert(expected_votes.size(),
                                      predict_vote(track_id, predicted_level));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_votes.size() == 0)
                begin
                    $display("%0t ns: unexpected result level %0d votes %0d len %0d bad %0d",
                             $time, voted_level, winning_votes, history_length, bad_level);
                    fail_count++;
                end
                else
                begin
                    want = expected_votes.pop_front();
                    check_field("voted_level", 5'(want.level), 5'(voted_level));
                    check_field("winning_votes", want.votes, winning_votes);
                    check_field("history_length", want.length, history_length);
                    check_field("bad_level", 5'(want.bad), 5'(bad_level));
                end
            end
            pending <= expected_votes.size();
        end
    end

endmodule

// ===== tb/per_track_window_majority_vote_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_track_window_majority_vote_top_tb
// drives prediction requests into the majority vote block under several
// window and level settings, with bursty requests and a stalling receiver;
// a side checker predicts every vote and counts mismatches
// ----------------------------------------------------------------------------
module per_track_window_majority_vote_top_tb;
    import pwmv_pkg::*;

    localparam int IDLE_LIMIT      = 4000;  // cycles with no transfer at all
    localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 200;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             track_id;
    logic [2:0]             predicted_level;
    logic                   out_valid;
    logic                   out_stall;
    logic [2:0]             voted_level;
    logic [4:0]             winning_votes;
    logic [4:0]             history_length;
    logic                   bad_level;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending;

    // receiver controls, set by the stimulus process
    int stall_pct;
    int hold_request;

    per_track_window_majority_vote_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .track_id        (track_id),
        .predicted_level (predicted_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .voted_level     (voted_level),
        .winning_votes   (winning_votes),
        .history_length  (history_length),
        .bad_level       (bad_level),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    window_vote_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .track_id        (track_id),
        .predicted_level (predicted_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .voted_level     (voted_level),
        .winning_votes   (winning_votes),
        .history_length  (history_length),
        .bad_level       (bad_level),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // one request: present at the falling edge, hold until taken at a rising edge
    task automatic send_request(input logic [7:0] trk, input logic [2:0] lvl);
        @(negedge clk);
        in_valid        <= 1'b1;
        track_id        <= trk;
        predicted_level <= lvl;
        do
        begin
            @(posedge clk);
        end
        while (!(in_valid && !in_stall));
    endtask

    // sender gap with valid low; n sets its length
    task automatic sender_gap(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // stop sending and let every outstanding vote come back, then wait for
    // the back end to settle
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    // receiver: random stall runs, or a long hold-off when asked
    initial
    begin : receiver
        int   run_left;
        int   hold_left;
        logic stall_now;
        out_stall = 1'b0;
        run_left  = 0;
        hold_left = 0;
        stall_now = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_request = 0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                // block fills up and pushes back on the sender
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_left  = $urandom_range(1, 10);
                    stall_now = ($urandom_range(0, 99) < stall_pct);
                end
                run_left--;
                out_stall <= stall_now;
            end
        end
    end

    // watchdog: ends the run if nothing moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("FAIL per_track_window_majority_vote_top");
        $finish;
    end

    initial
    begin : stimulus
        logic [4:0] win_tab   [NUM_PHASES];
        logic [3:0] lvl_tab   [NUM_PHASES];
        int         stall_tab [NUM_PHASES];
        int         gap_tab   [NUM_PHASES];
        int         burst_left;
        int         gap_max;
        int         pool_base;
        int         nl_eff;
        logic [7:0] trk;
        logic [2:0] lvl;

        // window and level settings: extremes, out-of-range values that
        // clamp, and a random pair at the end
        win_tab   = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd8, 5'd16, 5'd2, 5'd0};
        lvl_tab   = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd2, 4'd5, 4'd3, 4'd8, 4'd0};
        stall_tab = '{0, 30, 60, 10, 40, 0, 80, 20, 35};
        gap_tab   = '{0, 4, 10, 2, 6, 0, 3, 12, 5};
        win_tab[NUM_PHASES-1] = 5'($urandom_range(0, 31));
        lvl_tab[NUM_PHASES-1] = 4'($urandom_range(0, 15));

        rst_n           = 1'b0;
        in_valid        = 1'b0;
        track_id        = '0;
        predicted_level = '0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        stall_pct       = 25;
        hold_request    = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part under the reset setting: window 8, five levels
        send_request(8'd0,   3'd0);     // first request of a track
        send_request(8'd255, 3'd4);     // top track id, top valid level
        send_request(8'd10,  3'd7);     // bad level on a track never started
        send_request(8'd0,   3'd5);     // first bad level on a started track
        // one track through fill, ties and eviction of the oldest level
        send_request(8'd1, 3'd3);
        send_request(8'd1, 3'd1);       // tie goes to the lower level
        send_request(8'd1, 3'd1);
        send_request(8'd1, 3'd3);
        send_request(8'd1, 3'd3);
        send_request(8'd1, 3'd1);
        send_request(8'd1, 3'd2);
        send_request(8'd1, 3'd2);       // window now full
        send_request(8'd1, 3'd2);       // evicts the first level
        send_request(8'd1, 3'd4);
        send_request(8'd1, 3'd0);
        send_request(8'd1, 3'd6);       // bad level leaves the history alone
        send_request(8'd128, 3'd2);
        send_request(8'd255, 3'd6);
        send_request(8'h55, 3'd3);
        send_request(8'haa, 3'd1);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // registers change only with the block empty
            wait_for_results();
            write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(win_tab[p]));
            write_reg(REG_NUM_LEVELS, CFG_DATA_W'(lvl_tab[p]));
            @(negedge clk);
            cfg_we <= 1'b0;

            nl_eff = (lvl_tab[p] == 0) ? 1 :
                     ((lvl_tab[p] > MAX_LEVELS) ? MAX_LEVELS : int'(lvl_tab[p]));
            stall_pct  = stall_tab[p];
            gap_max    = gap_tab[p];
            burst_left = 0;
            pool_base  = $urandom_range(0, 255);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // long receiver hold-off while requests keep coming
                if (p == 2 && n == 60)
                begin
                    hold_request = 1;
                end
                // sender pauses until every vote is back
                if (p == 4 && n == 100)
                begin
                    wait_for_results();
                end
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    if (gap_max > 0)
                    begin
                        sender_gap($urandom_range(1, gap_max));
                    end
                end
                burst_left--;
                // mostly a handful of busy tracks so windows fill and wrap
                if ($urandom_range(0, 99) < 85)
                begin
                    trk = 8'(pool_base + $urandom_range(0, 5));
                end
                else
                begin
                    trk = 8'($urandom_range(0, 255));
                end
                // mostly valid levels, some out of range
                if ($urandom_range(0, 99) < 85)
                begin
                    lvl = 3'($urandom_range(0, nl_eff - 1));
                end
                else
                begin
                    lvl = 3'($urandom_range(0, 7));
                end
                send_request(trk, lvl);
            end
        end

        wait_for_results();
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("PASS per_track_window_majority_vote_top");
        end
        else
        begin
            $display("FAIL per_track_window_majority_vote_top");
        end
        $finish;
    end

endmodule
